### rtl/core/bounded_array_list_engine_macros.svh
// assertion macros for the array list engine
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
// assertion checked on every rising clock edge outside reset
`define BALE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication checked outside reset
`define BALE_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

### rtl/core/bale_pkg.sv
// shared types and constants of the array list engine
package bale_pkg;
	localparam int CAPACITY_DEF = 32;
	localparam int MAX_OUT = 32;

	localparam logic [2:0] ACT_APPEND = 3'd0;
	localparam logic [2:0] ACT_INSERT = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_REMVAL = 3'd3;
	localparam logic [2:0] ACT_DEDUP  = 3'd4;
	localparam logic [2:0] ACT_DUMP   = 3'd5;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_BADPOS   = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic [2:0]  action;
		logic signed [31:0] value;
		logic [5:0]  position;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic signed [31:0] element;
		logic [4:0]  index;
		logic [5:0]  removed_count;
		logic [5:0]  length_after;
		logic        last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input item
		logic rd;        // read store at rd index
		logic wr;        // write store
		logic [2:0] wsel;   // 0 value, 1 read data
		logic set_i;     // i <= start
		logic inc_i;
		logic dec_i;
		logic set_j;     // j <= i+1
		logic inc_j;
		logic len_inc;
		logic len_dec;
		logic cnt_inc;
		logic cap_ref;   // reference <= read data
		logic [1:0] rsel; // read index: 0 i, 1 i-1, 2 k+1, 3 j
		logic [1:0] wasel; // write index: 0 i, 1 len, 2 k
		logic set_k;     // k <= j for dedup, else i (compaction cursor)
		logic inc_k;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic pos_gt_len;
		logic pos_ge_len;
		logic empty;
		logic i_gt_pos;
		logic i_lt_len;
		logic j_lt_len;
		logic k1_lt_len;
		logic eq_val;
		logic eq_ref;
		logic dump_end;
		logic [2:0] action;
	} sts_t;
endpackage

### rtl/core/bale_if.sv
// valid ready channel interface
interface bale_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/bale_datapath.sv
// store, cursors and compare logic of the array list engine
module bale_datapath #(
	parameter int CAPACITY = bale_pkg::CAPACITY_DEF,
	parameter int AW = $clog2(CAPACITY),
	parameter int LW = $clog2(CAPACITY + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  bale_pkg::cmd_t cmd,
	input  bale_pkg::in_item_t in_item,
	output bale_pkg::sts_t sts,
	output logic signed [31:0] rdata,
	output logic [LW-1:0] len,
	output logic [LW-1:0] cnt,
	output logic [LW-1:0] icur
);
	logic signed [31:0] mem [CAPACITY];
	logic [2:0] act_q;
	logic signed [31:0] val_q, ref_q;
	logic [5:0] pos_q;
	logic [LW-1:0] len_q, i_q, j_q, k_q, cnt_q;
	logic [LW-1:0] ra, wa;
	logic [LW:0] posx, lenx;

	always_comb begin
		case (cmd.rsel)
			2'd0: ra = i_q;
			2'd1: ra = i_q - 1'b1;
			2'd2: ra = k_q + 1'b1;
			default: ra = j_q;
		endcase
		case (cmd.wasel)
			2'd0: wa = i_q;
			2'd1: wa = len_q;
			default: wa = k_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) rdata <= mem[ra[AW-1:0]];
		if (cmd.wr) mem[wa[AW-1:0]] <= (cmd.wsel == 3'd0) ? val_q : rdata;
		if (cmd.load) begin
			act_q <= in_item.action;
			val_q <= in_item.value;
			pos_q <= in_item.position;
		end
		if (cmd.cap_ref) ref_q <= rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0; cnt_q <= '0;
		end else begin
			if (cmd.load) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + 1'b1;
			if (cmd.len_inc) len_q <= len_q + 1'b1;
			else if (cmd.len_dec) len_q <= len_q - 1'b1;
			if (cmd.set_i) begin
				if (act_q == bale_pkg::ACT_INSERT) i_q <= len_q;
				else if (act_q == bale_pkg::ACT_REMOVE) i_q <= LW'(pos_q);
				else i_q <= '0;
			end else if (cmd.inc_i) i_q <= i_q + 1'b1;
			else if (cmd.dec_i) i_q <= i_q - 1'b1;
			if (cmd.set_j) j_q <= i_q + 1'b1;
			else if (cmd.inc_j) j_q <= j_q + 1'b1;
			if (cmd.set_k) k_q <= (act_q == bale_pkg::ACT_DEDUP) ? j_q : i_q;
			else if (cmd.inc_k) k_q <= k_q + 1'b1;
		end
	end

	assign posx = (LW + 1)'(pos_q);
	assign lenx = {1'b0, len_q};

	always_comb begin
		sts.full       = (len_q >= LW'(CAPACITY));
		sts.pos_gt_len = posx > lenx;
		sts.pos_ge_len = posx >= lenx;
		sts.empty      = (len_q == '0);
		sts.i_gt_pos   = {1'b0, i_q} > posx;
		sts.i_lt_len   = i_q < len_q;
		sts.j_lt_len   = j_q < len_q;
		sts.k1_lt_len  = ({1'b0, k_q} + 1'b1) < lenx;
		sts.eq_val     = rdata == val_q;
		sts.eq_ref     = rdata == ref_q;
		sts.dump_end   = ({1'b0, i_q} + 1'b1 >= lenx) ||
			({1'b0, i_q} + 1'b1 >= (LW + 1)'(bale_pkg::MAX_OUT));
		sts.action     = act_q;
	end

	assign len = len_q;
	assign cnt = cnt_q;
	assign icur = i_q;
endmodule

### rtl/core/bale_ctrl.sv
// controller state machine of the array list engine
`include "bounded_array_list_engine_macros.svh"
module bale_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] out_status,
	output logic out_dump,
	output logic out_last,
	output bale_pkg::cmd_t cmd,
	input  bale_pkg::sts_t sts
);
	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_DEC   = 11'b00000000010,
		S_SHUP  = 11'b00000000100,
		S_SHUPW = 11'b00000001000,
		S_KRD   = 11'b00000010000,
		S_KWR   = 11'b00000100000,
		S_SCAN  = 11'b00001000000,
		S_TEST  = 11'b00010000000,
		S_REF   = 11'b00100000000,
		S_DRD   = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t st_q, ret_q;
	logic [2:0] stat_q;
	logic dump_q, last_q, vld_q;

	// ret_q: S_SCAN for remove value, S_TEST for dedup, S_IDLE for remove at, S_OUT for dump
	always_comb begin
		cmd = '0;
		case (st_q)
			S_IDLE: cmd.load = in_valid && !vld_q;
			S_DEC: begin
				cmd.set_i = 1'b1;
				if (sts.action == bale_pkg::ACT_APPEND && !sts.full) begin
					cmd.wr = 1'b1; cmd.wasel = 2'd1; cmd.len_inc = 1'b1;
				end
			end
			S_SHUP: if (sts.i_gt_pos) begin
				cmd.rd = 1'b1; cmd.rsel = 2'd1;
			end else begin
				cmd.wr = 1'b1; cmd.wasel = 2'd0; cmd.len_inc = 1'b1;
			end
			S_SHUPW: begin
				cmd.wr = 1'b1; cmd.wsel = 3'd1; cmd.wasel = 2'd0; cmd.dec_i = 1'b1;
			end
			S_KRD: if (sts.k1_lt_len) begin
				cmd.rd = 1'b1; cmd.rsel = 2'd2;
			end else begin
				cmd.len_dec = 1'b1;
			end
			S_KWR: begin
				cmd.wr = 1'b1; cmd.wsel = 3'd1; cmd.wasel = 2'd2; cmd.inc_k = 1'b1;
			end
			S_SCAN: begin
				if (ret_q == S_SCAN) begin
					if (sts.i_lt_len) begin cmd.rd = 1'b1; cmd.rsel = 2'd0; end
				end else begin
					if (sts.j_lt_len) begin cmd.rd = 1'b1; cmd.rsel = 2'd3; end
					else cmd.inc_i = 1'b1;
				end
			end
			S_TEST: begin
				if (ret_q == S_SCAN) begin
					if (sts.eq_val) begin cmd.set_k = 1'b1; cmd.cnt_inc = 1'b1; end
					else cmd.inc_i = 1'b1;
				end else begin
					if (sts.eq_ref) begin cmd.set_k = 1'b1; cmd.cnt_inc = 1'b1; end
					else cmd.inc_j = 1'b1;
				end
			end
			S_REF: begin
				if (sts.i_lt_len) begin cmd.rd = 1'b1; cmd.rsel = 2'd0; end
			end
			S_DRD: begin
				if (ret_q == S_OUT) begin
					cmd.rd = 1'b1; cmd.rsel = 2'd0;
				end else if (ret_q == S_IDLE) begin
					cmd.set_k = 1'b1;
				end else begin
					cmd.cap_ref = 1'b1; cmd.set_j = 1'b1;
				end
			end
			S_OUT: if (vld_q && out_ready && dump_q && !last_q) cmd.inc_i = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; ret_q <= S_IDLE; stat_q <= bale_pkg::ST_OK;
			dump_q <= 1'b0; last_q <= 1'b0; vld_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (in_valid && !vld_q) st_q <= S_DEC;
				S_DEC: begin
					stat_q <= bale_pkg::ST_OK; dump_q <= 1'b0; last_q <= 1'b1;
					case (sts.action)
						bale_pkg::ACT_APPEND: begin
							if (sts.full) stat_q <= bale_pkg::ST_FULL;
							st_q <= S_OUT; vld_q <= 1'b1;
						end
						bale_pkg::ACT_INSERT: begin
							if (sts.full) begin
								stat_q <= bale_pkg::ST_FULL; st_q <= S_OUT; vld_q <= 1'b1;
							end else if (sts.pos_gt_len) begin
								stat_q <= bale_pkg::ST_BADPOS; st_q <= S_OUT; vld_q <= 1'b1;
							end else st_q <= S_SHUP;
						end
						bale_pkg::ACT_REMOVE: begin
							if (sts.pos_ge_len) begin
								stat_q <= bale_pkg::ST_BADPOS; st_q <= S_OUT; vld_q <= 1'b1;
							end else begin
								ret_q <= S_IDLE; st_q <= S_DRD;
							end
						end
						bale_pkg::ACT_REMVAL: begin ret_q <= S_SCAN; st_q <= S_SCAN; end
						bale_pkg::ACT_DEDUP: begin ret_q <= S_TEST; st_q <= S_REF; end
						bale_pkg::ACT_DUMP: begin
							if (sts.empty) begin
								stat_q <= bale_pkg::ST_EMPTY; st_q <= S_OUT; vld_q <= 1'b1;
							end else begin
								dump_q <= 1'b1; ret_q <= S_OUT; st_q <= S_DRD;
							end
						end
						default: begin st_q <= S_OUT; vld_q <= 1'b1; end
					endcase
				end
				S_SHUP: if (!sts.i_gt_pos) begin
					st_q <= S_OUT; vld_q <= 1'b1;
				end else st_q <= S_SHUPW;
				S_SHUPW: st_q <= S_SHUP;
				S_DRD: begin
					if (ret_q == S_OUT) begin
						st_q <= S_OUT; vld_q <= 1'b1; last_q <= sts.dump_end;
					end else if (ret_q == S_IDLE) st_q <= S_KRD;
					else st_q <= S_SCAN;
				end
				S_KRD: if (sts.k1_lt_len) st_q <= S_KWR;
				else if (ret_q == S_IDLE) begin st_q <= S_OUT; vld_q <= 1'b1; end
				else st_q <= S_SCAN;
				S_KWR: st_q <= S_KRD;
				S_SCAN: begin
					if (ret_q == S_SCAN) begin
						if (sts.i_lt_len) st_q <= S_TEST;
						else begin
							st_q <= S_OUT; vld_q <= 1'b1;
						end
					end else begin
						if (sts.j_lt_len) st_q <= S_TEST;
						else st_q <= S_REF;
					end
				end
				S_TEST: begin
					if ((ret_q == S_SCAN && sts.eq_val) || (ret_q != S_SCAN && sts.eq_ref))
						st_q <= S_KRD;
					else st_q <= S_SCAN;
				end
				S_REF: if (sts.i_lt_len) st_q <= S_DRD;
				else begin st_q <= S_OUT; vld_q <= 1'b1; end
				S_OUT: if (vld_q && out_ready) begin
					if (dump_q && !last_q) begin
						st_q <= S_DRD; vld_q <= 1'b0;
					end else begin
						st_q <= S_IDLE; vld_q <= 1'b0;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (st_q == S_IDLE) && !vld_q;
	assign out_valid = vld_q;
	assign out_status = stat_q;
	assign out_dump = dump_q;
	assign out_last = last_q;

	`BALE_IMPLY(a_ready_idle, clk, arst_n, in_ready, !out_valid, "ready while result pending")
	`BALE_IMPLY(a_valid_out, clk, arst_n, out_valid, st_q == S_OUT, "valid outside output state")
	`BALE_ASSERT(a_onehot, clk, arst_n, $onehot(st_q), "state not one-hot")
endmodule

### rtl/core/bounded_array_list_engine.sv
// append, unused actions and error cases go from decode straight to the result state
// insert and remove at shift the entries one store read and write at a time; remove value
// and dedup compact the list after each match
// dump: one result per entry, up to MAX_OUT entries, one store read each
// one transaction at a time; next input taken once the last result is delivered
// arst_n clears length, counters and controller; store contents stay undefined
module bounded_array_list_engine #(
	parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	bale_if.sink in_ch,
	bale_if.source out_ch
);
	localparam int LW = $clog2(CAPACITY + 1);
	bale_pkg::cmd_t cmd;
	bale_pkg::sts_t sts;
	bale_pkg::in_item_t in_item;
	logic signed [31:0] rdata;
	logic [LW-1:0] len, cnt, icur;
	logic [2:0] st;
	logic dump, last;

	assign in_item = in_ch.data;

	bale_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_status(st), .out_dump(dump), .out_last(last),
		.cmd, .sts
	);

	bale_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk, .arst_n, .cmd, .in_item, .sts, .rdata, .len, .cnt, .icur
	);

	always_comb begin
		out_ch.data = '0;
		out_ch.data.status = st;
		out_ch.data.length_after = 6'(len);
		out_ch.data.last = last;
		if (dump && st == bale_pkg::ST_OK) begin
			out_ch.data.element = rdata;
			out_ch.data.index = 5'(icur);
		end
		if (sts.action == bale_pkg::ACT_REMVAL) begin
			out_ch.data.removed_count = 6'(cnt);
			out_ch.data.status = (cnt == '0) ? bale_pkg::ST_NOTFOUND : bale_pkg::ST_OK;
		end
		if (sts.action == bale_pkg::ACT_DEDUP) out_ch.data.removed_count = 6'(cnt);
	end
endmodule
